>>> sv/lkm_pkg.sv
// ----------------------------------------------------------------------------
// lkm_pkg : shared types and constants for the layered key matrix core
// Payload structs, queue entry, state encodings, usage codes and the keymap.
// ----------------------------------------------------------------------------
package lkm_pkg;

   localparam int COLUMNS             = 5;
   localparam int ROWS                = 7;
   localparam int REPORT_SLOTS        = 6;
   localparam int LAYERS              = 4;
   localparam int PAGE                = 40;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = 3;                       // page stride is 8 rows
   localparam int USED_W = $clog2(REPORT_SLOTS + 1);

   // keymap entry encoding
   localparam int MOD_BIT       = 8;
   localparam int TAG_SHIFT_BIT = 12;
   localparam int TAG_ALT_BIT   = 13;

   localparam logic [15:0] VK_SYM   = 16'h0100;
   localparam logic [15:0] VK_ALT   = 16'h0101;
   localparam logic [15:0] VK_CAPS  = 16'h0102;
   localparam logic [15:0] VK_SHIFT = 16'h0103;
   localparam logic [15:0] VK_CTRL  = 16'h0104;

   // HID usage codes
   localparam logic [7:0] U_CTRL_L  = 8'hE0;
   localparam logic [7:0] U_SHIFT_L = 8'hE1;
   localparam logic [7:0] U_ALT_L   = 8'hE2;
   localparam logic [7:0] U_ESC     = 8'h29;
   localparam logic [7:0] U_TAB     = 8'h2B;
   localparam logic [7:0] U_RIGHT   = 8'h4F;
   localparam logic [7:0] U_LEFT    = 8'h50;
   localparam logic [7:0] U_DOWN    = 8'h51;
   localparam logic [7:0] U_UP      = 8'h52;

   typedef struct packed {
      logic [6:0] col_one_rows;
      logic [6:0] col_two_rows;
      logic [6:0] col_three_rows;
      logic [6:0] col_four_rows;
      logic [6:0] col_five_rows;
      logic       jog_back;
      logic       jog_enter;
      logic       jog_up;
      logic       jog_down;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] slot_zero;
      logic [7:0] slot_one;
      logic [7:0] slot_two;
      logic [7:0] slot_three;
      logic [7:0] slot_four;
      logic [7:0] slot_five;
      logic [2:0] used_slots;
   } rsp_payload_type;

   typedef logic [COLUMNS-1:0][ROWS-1:0] scan_type;

   typedef enum logic [2:0] {
      JOG_NONE,
      JOG_BACK,
      JOG_ENTER,
      JOG_UP,
      JOG_DOWN
   } jog_kind_type;

   typedef struct packed {
      scan_type     scan;
      jog_kind_type jog;
      logic         menu_combo;
   } queue_entry_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_out_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_FINISH
   } back_state_type;

   // four layers of 5 columns x 8 rows; row 8 of each column is unused
   localparam logic [15:0] KEYMAP_ROM [LAYERS][PAGE] = '{
      '{16'h0014, 16'h001A, 16'h0100, 16'h0004, 16'h0101, 16'h002C, 16'h002B, 16'h0000,
        16'h0008, 16'h0016, 16'h0007, 16'h0013, 16'h001B, 16'h001D, 16'h0103, 16'h0000,
        16'h0015, 16'h000A, 16'h0017, 16'h0104, 16'h0019, 16'h0006, 16'h0009, 16'h0000,
        16'h0018, 16'h000B, 16'h001C, 16'h0028, 16'h0005, 16'h0011, 16'h000D, 16'h0000,
        16'h0012, 16'h000F, 16'h000C, 16'h002A, 16'h1021, 16'h0010, 16'h000E, 16'h0000},
      '{16'h2014, 16'h201A, 16'h0100, 16'h2004, 16'h0101, 16'h002C, 16'h0031, 16'h0000,
        16'h2008, 16'h2016, 16'h2007, 16'h2013, 16'h201B, 16'h201D, 16'h0103, 16'h0000,
        16'h2015, 16'h200A, 16'h2017, 16'h0104, 16'h2019, 16'h2006, 16'h2009, 16'h0000,
        16'h2018, 16'h200B, 16'h201C, 16'h0030, 16'h2005, 16'h2011, 16'h200D, 16'h0000,
        16'h2012, 16'h200F, 16'h200C, 16'h002F, 16'h0035, 16'h2010, 16'h200E, 16'h0000},
      '{16'h1020, 16'h001E, 16'h0100, 16'h1025, 16'h0101, 16'h002C, 16'h0027, 16'h0000,
        16'h001F, 16'h0021, 16'h0022, 16'h101F, 16'h0025, 16'h0024, 16'h0103, 16'h0000,
        16'h0020, 16'h0038, 16'h1026, 16'h0104, 16'h1038, 16'h0026, 16'h0023, 16'h0000,
        16'h002E, 16'h1033, 16'h1027, 16'h0028, 16'h101E, 16'h0036, 16'h0033, 16'h0000,
        16'h102E, 16'h1034, 16'h002D, 16'h002A, 16'h002E, 16'h0037, 16'h0034, 16'h0000},
      '{16'h1020, 16'h003A, 16'h0100, 16'h1025, 16'h0101, 16'h002C, 16'h0043, 16'h0000,
        16'h003B, 16'h003D, 16'h003E, 16'h101F, 16'h0041, 16'h0040, 16'h0103, 16'h0000,
        16'h003C, 16'h0038, 16'h1026, 16'h0104, 16'h1038, 16'h0042, 16'h003F, 16'h0000,
        16'h0035, 16'h1033, 16'h1027, 16'h1030, 16'h101E, 16'h1036, 16'h0033, 16'h0000,
        16'h1031, 16'h1034, 16'h1024, 16'h102F, 16'h002E, 16'h1037, 16'h0034, 16'h0000}
   };

   function automatic logic [15:0] keymap_code(input logic [1:0] layer,
                                               input logic [5:0] pos);
      return KEYMAP_ROM[layer][pos];
   endfunction

endpackage

>>> sv/lkm_front.sv
// ----------------------------------------------------------------------------
// lkm_front : scan intake and classification
// Accepts scans, resolves jog priority and the menu chord, and queues them.
// ----------------------------------------------------------------------------
module lkm_front
   import lkm_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   input  logic            pop,
   output queue_out_type   q_out
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   queue_entry_type  classified;
   logic             push;
   logic             do_pop;

   always_comb begin
      classified.scan[0] = req_data.col_one_rows;
      classified.scan[1] = req_data.col_two_rows;
      classified.scan[2] = req_data.col_three_rows;
      classified.scan[3] = req_data.col_four_rows;
      classified.scan[4] = req_data.col_five_rows;
      priority if (req_data.jog_back) begin
         classified.jog = JOG_BACK;
      end else if (req_data.jog_enter) begin
         classified.jog = JOG_ENTER;
      end else if (req_data.jog_up) begin
         classified.jog = JOG_UP;
      end else if (req_data.jog_down) begin
         classified.jog = JOG_DOWN;
      end else begin
         classified.jog = JOG_NONE;
      end
      // menu chord: column two row seven and column three row four held
      classified.menu_combo = !req_data.col_two_rows[6] && !req_data.col_three_rows[3];
   end

   assign req_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign do_pop    = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= classified;
      end
   end

   assign q_out.valid = (count_ff != '0);
   assign q_out.entry = entries_ff[rd_ptr_ff];

endmodule

>>> sv/lkm_back.sv
// ----------------------------------------------------------------------------
// lkm_back : key sequencer and report builder
// Walks one key per cycle through the keymap, tracks the modifier latches,
// applies the jog and menu rules, and holds the finished report.
// ----------------------------------------------------------------------------
module lkm_back
   import lkm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  queue_out_type   q_out,
   output logic            pop,
   input  logic            csr_wr_en,
   input  logic            csr_wr_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   back_state_type   state_ff, state_in;
   queue_entry_type  work_ff, work_in;
   scan_type         prev_scan_ff, prev_scan_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [1:0]       layer_ff, layer_in;
   logic [7:0]       slots_ff [REPORT_SLOTS];
   logic [7:0]       slots_in [REPORT_SLOTS];
   logic [USED_W-1:0] used_ff, used_in;
   logic             have_first_ff, have_first_in;
   logic [1:0]       first_tags_ff, first_tags_in;
   logic             alt_ff, alt_in;
   logic             sym_ff, sym_in;
   logic             shift_ff, shift_in;
   logic             menu_ff, menu_in;
   logic             jog_present_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_data_ff, rsp_data_in;

   logic [15:0]      code;
   logic             now_pressed;
   logic             was_pressed;
   logic [7:0]       emit_code [3];
   logic [1:0]       emit_count;
   logic [USED_W:0]  used_sum;
   logic [USED_W-1:0] used_scan;
   logic [USED_W-1:0] offset;
   logic             last_key;
   logic             out_free;
   logic [7:0]       fin_slots [REPORT_SLOTS];
   logic [USED_W-1:0] fin_used;
   logic             jog_hit;
   logic [7:0]       jog_code;

   assign code        = keymap_code(layer_ff, {col_ff, row_ff});
   assign now_pressed = !work_ff.scan[col_ff][row_ff];
   assign was_pressed = !prev_scan_ff[col_ff][row_ff];
   assign last_key    = (col_ff == COL_W'(COLUMNS - 1)) && (row_ff == ROW_W'(ROWS - 1));
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      work_in       = work_ff;
      prev_scan_in  = prev_scan_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      layer_in      = layer_ff;
      slots_in      = slots_ff;
      used_in       = used_ff;
      have_first_in = have_first_ff;
      first_tags_in = first_tags_ff;
      alt_in        = alt_ff;
      sym_in        = sym_ff;
      shift_in      = shift_ff;
      menu_in       = menu_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      pop           = 1'b0;
      emit_code[0]  = '0;
      emit_code[1]  = '0;
      emit_code[2]  = '0;
      emit_count    = '0;
      used_sum      = '0;
      used_scan     = used_ff;
      offset        = '0;
      fin_slots     = slots_ff;
      fin_used      = used_ff;
      jog_hit       = 1'b0;
      jog_code      = '0;

      unique case (state_ff)
         BK_IDLE: begin
            if (q_out.valid) begin
               pop           = 1'b1;
               work_in       = q_out.entry;
               layer_in      = {sym_ff, alt_ff};
               col_in        = '0;
               row_in        = '0;
               used_in       = '0;
               have_first_in = 1'b0;
               first_tags_in = '0;
               for (int i = 0; i < REPORT_SLOTS; i++) begin
                  slots_in[i] = '0;
               end
               state_in = BK_SCAN;
            end
         end

         BK_SCAN: begin
            if (code[MOD_BIT]) begin
               priority if (code == VK_ALT) begin
                  alt_in = now_pressed;
               end else if (code == VK_CAPS) begin
                  alt_in = alt_ff;
               end else if (code == VK_SHIFT) begin
                  if (!was_pressed && now_pressed) begin
                     shift_in = !shift_ff;
                  end
               end else if (code == VK_CTRL) begin
                  if (now_pressed) begin
                     emit_code[0] = U_CTRL_L;
                     emit_count   = 2'd1;
                  end
               end else begin
                  sym_in = now_pressed;
               end
            end else if (now_pressed) begin
               if (!have_first_ff) begin
                  have_first_in = 1'b1;
                  first_tags_in = {code[TAG_ALT_BIT], code[TAG_SHIFT_BIT]};
                  unique case ({code[TAG_SHIFT_BIT] != shift_ff, code[TAG_ALT_BIT]})
                     2'b11: begin
                        emit_code[0] = U_SHIFT_L;
                        emit_code[1] = U_ALT_L;
                        emit_code[2] = code[7:0];
                        emit_count   = 2'd3;
                     end
                     2'b10: begin
                        emit_code[0] = U_SHIFT_L;
                        emit_code[1] = code[7:0];
                        emit_count   = 2'd2;
                     end
                     2'b01: begin
                        emit_code[0] = U_ALT_L;
                        emit_code[1] = code[7:0];
                        emit_count   = 2'd2;
                     end
                     default: begin
                        emit_code[0] = code[7:0];
                        emit_count   = 2'd1;
                     end
                  endcase
               end else if (code[15:12] == {2'b00, first_tags_ff}) begin
                  emit_code[0] = code[7:0];
                  emit_count   = 2'd1;
               end
            end

            // drop whatever does not fit in the report
            for (int i = 0; i < REPORT_SLOTS; i++) begin
               offset = USED_W'(i) - used_ff;
               if ((USED_W'(i) >= used_ff) && (offset < USED_W'(emit_count))) begin
                  slots_in[i] = emit_code[offset[1:0]];
               end
            end
            used_sum  = {1'b0, used_ff} + (USED_W + 1)'(emit_count);
            used_scan = (used_sum > (USED_W + 1)'(REPORT_SLOTS)) ?
                        USED_W'(REPORT_SLOTS) : used_sum[USED_W-1:0];
            used_in   = used_scan;

            if (last_key || (used_scan >= USED_W'(REPORT_SLOTS))) begin
               state_in = BK_FINISH;
            end else if (row_ff == ROW_W'(ROWS - 1)) begin
               row_in = '0;
               col_in = col_ff + 1'b1;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end

         BK_FINISH: begin
            if (menu_ff) begin
               for (int i = 0; i < REPORT_SLOTS; i++) begin
                  fin_slots[i] = '0;
               end
               fin_used = '0;
            end else if (jog_present_ff) begin
               unique case (work_ff.jog)
                  JOG_BACK: begin
                     if (work_ff.menu_combo) begin
                        menu_in = 1'b1;
                        for (int i = 0; i < REPORT_SLOTS; i++) begin
                           fin_slots[i] = '0;
                        end
                        fin_used = '0;
                     end else begin
                        jog_hit  = 1'b1;
                        jog_code = U_ESC;
                     end
                  end
                  JOG_ENTER: begin
                     jog_hit  = 1'b1;
                     jog_code = U_TAB;
                  end
                  JOG_UP: begin
                     jog_hit  = 1'b1;
                     jog_code = sym_ff ? U_RIGHT : U_UP;
                  end
                  JOG_DOWN: begin
                     jog_hit  = 1'b1;
                     jog_code = sym_ff ? U_LEFT : U_DOWN;
                  end
                  default: begin
                     jog_hit = 1'b0;
                  end
               endcase
               if (jog_hit && (used_ff < USED_W'(REPORT_SLOTS))) begin
                  fin_slots[used_ff] = jog_code;
                  fin_used           = used_ff + 1'b1;
               end
            end

            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.slot_zero  = fin_slots[0];
               rsp_data_in.slot_one   = fin_slots[1];
               rsp_data_in.slot_two   = fin_slots[2];
               rsp_data_in.slot_three = fin_slots[3];
               rsp_data_in.slot_four  = fin_slots[4];
               rsp_data_in.slot_five  = fin_slots[5];
               rsp_data_in.used_slots = fin_used;
               prev_scan_in           = work_ff.scan;
               state_in               = BK_IDLE;
            end else begin
               menu_in = menu_ff;
            end
         end

         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= BK_IDLE;
         prev_scan_ff   <= '1;
         alt_ff         <= 1'b0;
         sym_ff         <= 1'b0;
         shift_ff       <= 1'b0;
         menu_ff        <= 1'b0;
         jog_present_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         col_ff         <= '0;
         row_ff         <= '0;
         used_ff        <= '0;
         have_first_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_scan_ff  <= prev_scan_in;
         alt_ff        <= alt_in;
         sym_ff        <= sym_in;
         shift_ff      <= shift_in;
         menu_ff       <= menu_in;
         rsp_valid_ff  <= rsp_valid_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         used_ff       <= used_in;
         have_first_ff <= have_first_in;
         if (csr_wr_en) begin
            jog_present_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff       <= work_in;
      layer_ff      <= layer_in;
      slots_ff      <= slots_in;
      first_tags_ff <= first_tags_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sv/layered_key_matrix_to_hid_report_core.sv
// ----------------------------------------------------------------------------
// layered_key_matrix_to_hid_report_core : key matrix scan to HID report
// Turns each scan of a 5x7 active-low matrix plus jog buttons into one
// six-slot HID usage report with a slot count.
// ----------------------------------------------------------------------------
// Each accepted scan gives exactly one report. The back end loads a scan,
// reads one keymap entry per cycle for each key visited (fewer keys when
// the report fills up early), then applies the jog buttons and hands the
// report to the output register once it is free. Scans queue ahead of the
// sequencer (QUEUE_DEPTH entries) and a finished report waits in its own
// register, so intake and delivery stall independently. The jog_present
// bit is written through csr_wr_en/csr_wr_data; the user must write it
// only while the core is idle, since the core does not enforce this.
module layered_key_matrix_to_hid_report_core
   import lkm_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data,
   input  logic            csr_wr_en,
   input  logic            csr_wr_data
);

   queue_out_type q_out;
   logic          pop;

   lkm_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .pop      (pop),
      .q_out    (q_out)
   );

   lkm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_out      (q_out),
      .pop        (pop),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

>>> sv/lkm_checker.sv
// ----------------------------------------------------------------------------
// lkm_checker : port-level checks for the key matrix core
// Watches the result channel for report consistency and reset behavior.
// ----------------------------------------------------------------------------
module lkm_checker
   import lkm_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_data
);

   // a report held back by the receiver stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("report dropped while stalled");

   a_used_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.used_slots <= 3'd6))
      else $error("slot count out of range");

   // slot five reads as zero whenever the count leaves it unused
   a_tail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.used_slots <= 3'd5) |-> (rsp_data.slot_five == 8'h00))
      else $error("slot beyond count not cleared");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("report offered right after reset");

endmodule

bind layered_key_matrix_to_hid_report_core lkm_checker u_lkm_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

>>> tb/sv/tb_layered_key_matrix_to_hid_report_core.sv
// ----------------------------------------------------------------------------
// tb_layered_key_matrix_to_hid_report_core : self-checking bench
// Drives matrix scans with jog buttons through four jog-dial settings and
// checks every HID report against a scan-by-scan prediction of the keymap
// layers, latches, shift toggle, report limit and menu mode.
// ----------------------------------------------------------------------------
module tb_layered_key_matrix_to_hid_report_core;
   import lkm_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int ERR_PRINT_MAX  = 10;

   // held-key masks: bit c*7+r set means column c, row r is pressed
   localparam logic [34:0] K_SYM   = 35'd1 << 2;
   localparam logic [34:0] K_ALT   = 35'd1 << 4;
   localparam logic [34:0] K_SHIFT = 35'd1 << 13;
   localparam logic [34:0] K_CTRL  = 35'd1 << 17;

   localparam logic [3:0] BTN_NONE  = 4'b0000;
   localparam logic [3:0] BTN_BACK  = 4'b1000;
   localparam logic [3:0] BTN_ENTER = 4'b0100;
   localparam logic [3:0] BTN_UP    = 4'b0010;
   localparam logic [3:0] BTN_DOWN  = 4'b0001;

   // layer x (column * 8 + row); row 7 of each column is never visited
   localparam logic [15:0] KEY_LAYOUT [4][40] = '{
      '{16'h0014, 16'h001A, VK_SYM,   16'h0004, VK_ALT,   16'h002C, 16'h002B, 16'h0000,
        16'h0008, 16'h0016, 16'h0007, 16'h0013, 16'h001B, 16'h001D, VK_SHIFT, 16'h0000,
        16'h0015, 16'h000A, 16'h0017, VK_CTRL,  16'h0019, 16'h0006, 16'h0009, 16'h0000,
        16'h0018, 16'h000B, 16'h001C, 16'h0028, 16'h0005, 16'h0011, 16'h000D, 16'h0000,
        16'h0012, 16'h000F, 16'h000C, 16'h002A, 16'h1021, 16'h0010, 16'h000E, 16'h0000},
      '{16'h2014, 16'h201A, VK_SYM,   16'h2004, VK_ALT,   16'h002C, 16'h0031, 16'h0000,
        16'h2008, 16'h2016, 16'h2007, 16'h2013, 16'h201B, 16'h201D, VK_SHIFT, 16'h0000,
        16'h2015, 16'h200A, 16'h2017, VK_CTRL,  16'h2019, 16'h2006, 16'h2009, 16'h0000,
        16'h2018, 16'h200B, 16'h201C, 16'h0030, 16'h2005, 16'h2011, 16'h200D, 16'h0000,
        16'h2012, 16'h200F, 16'h200C, 16'h002F, 16'h0035, 16'h2010, 16'h200E, 16'h0000},
      '{16'h1020, 16'h001E, VK_SYM,   16'h1025, VK_ALT,   16'h002C, 16'h0027, 16'h0000,
        16'h001F, 16'h0021, 16'h0022, 16'h101F, 16'h0025, 16'h0024, VK_SHIFT, 16'h0000,
        16'h0020, 16'h0038, 16'h1026, VK_CTRL,  16'h1038, 16'h0026, 16'h0023, 16'h0000,
        16'h002E, 16'h1033, 16'h1027, 16'h0028, 16'h101E, 16'h0036, 16'h0033, 16'h0000,
        16'h102E, 16'h1034, 16'h002D, 16'h002A, 16'h002E, 16'h0037, 16'h0034, 16'h0000},
      '{16'h1020, 16'h003A, VK_SYM,   16'h1025, VK_ALT,   16'h002C, 16'h0043, 16'h0000,
        16'h003B, 16'h003D, 16'h003E, 16'h101F, 16'h0041, 16'h0040, VK_SHIFT, 16'h0000,
        16'h003C, 16'h0038, 16'h1026, VK_CTRL,  16'h1038, 16'h0042, 16'h003F, 16'h0000,
        16'h0035, 16'h1033, 16'h1027, 16'h1030, 16'h101E, 16'h1036, 16'h0033, 16'h0000,
        16'h1031, 16'h1034, 16'h1024, 16'h102F, 16'h002E, 16'h1037, 16'h0034, 16'h0000}
   };

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_data;
   logic            csr_wr_en;
   logic            csr_wr_data;

   layered_key_matrix_to_hid_report_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // mirrored keyboard state
   logic [6:0] last_scan [COLUMNS];
   logic       alt_held;
   logic       sym_held;
   logic       shift_on;
   logic       ctrl_held;
   logic       menu_on;
   logic       jog_enabled;
   logic [7:0] report_codes [REPORT_SLOTS];
   int         report_count;

   req_payload_type scan_queue [$];
   rsp_payload_type report_queue [$];

   int error_count;
   int scans_sent;
   int reports_checked;
   int full_reports;
   int jog_codes;
   int burst_left;
   int gap_left;
   int idle_cycles;
   int cycle_count;
   int stall_mode;
   int stall_run;
   logic stall_level;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic logic [34:0] key_at(input int col, input int row);
      return 35'd1 << (col * 7 + row);
   endfunction

   function automatic req_payload_type make_scan(input logic [34:0] held,
                                                 input logic [3:0] buttons);
      req_payload_type s;
      s.col_one_rows   = ~held[6:0];
      s.col_two_rows   = ~held[13:7];
      s.col_three_rows = ~held[20:14];
      s.col_four_rows  = ~held[27:21];
      s.col_five_rows  = ~held[34:28];
      {s.jog_back, s.jog_enter, s.jog_up, s.jog_down} = buttons;
      return s;
   endfunction

   // mostly sparse presses with modifiers held across scans, some dense noise
   function automatic req_payload_type random_scan(input bit allow_menu);
      logic [34:0] held;
      logic [3:0]  buttons;
      int          pick;
      int          keys;
      held = '0;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         held = 35'({$urandom, $urandom});
      end else begin
         keys = (pick < 25) ? 0 : (pick < 80) ? $urandom_range(1, 3) : $urandom_range(4, 9);
         for (int i = 0; i < keys; i++)
            held |= key_at($urandom_range(0, 4), $urandom_range(0, 6));
      end
      if ($urandom_range(0, 99) < 35) held |= K_ALT;
      if ($urandom_range(0, 99) < 35) held |= K_SYM;
      if ($urandom_range(0, 99) < 20) held |= K_SHIFT;
      if ($urandom_range(0, 99) < 20) held |= K_CTRL;
      for (int i = 0; i < 4; i++)
         buttons[i] = ($urandom_range(0, 3) == 0);
      // keep the menu combination out until the last phase
      if (!allow_menu && (buttons & BTN_BACK) != 0 && (held & K_SHIFT) != 0
          && (held & K_CTRL) != 0)
         buttons &= ~BTN_BACK;
      return make_scan(held, buttons);
   endfunction

   function automatic void add_usage(input logic [7:0] usage);
      if (report_count < REPORT_SLOTS) begin
         report_codes[report_count] = usage;
         report_count++;
      end
   endfunction

   function automatic rsp_payload_type predict_report(input req_payload_type scan_in);
      logic [6:0]  rows_now [COLUMNS];
      logic [1:0]  layer;
      logic        have_lead;
      logic [3:0]  lead_tags;
      logic [15:0] entry;
      logic        pressed;
      logic        was_pressed;
      rsp_payload_type rep;
      rows_now[0] = scan_in.col_one_rows;
      rows_now[1] = scan_in.col_two_rows;
      rows_now[2] = scan_in.col_three_rows;
      rows_now[3] = scan_in.col_four_rows;
      rows_now[4] = scan_in.col_five_rows;
      layer = {sym_held, alt_held};
      have_lead = 1'b0;
      lead_tags = '0;
      report_count = 0;
      for (int i = 0; i < REPORT_SLOTS; i++) report_codes[i] = '0;

      for (int c = 0; c < COLUMNS; c++) begin
         for (int r = 0; r < ROWS; r++) begin
            // scan stops once the report is full
            if (report_count < REPORT_SLOTS) begin
               entry       = KEY_LAYOUT[layer][c * 8 + r];
               pressed     = !rows_now[c][r];
               was_pressed = !last_scan[c][r];
               if (entry[MOD_BIT]) begin
                  case (entry)
                     VK_ALT: alt_held = pressed;
                     VK_CAPS: ;
                     VK_SHIFT: if (!was_pressed && pressed) shift_on = !shift_on;
                     VK_CTRL: begin
                        ctrl_held = pressed;
                        if (pressed) add_usage(U_CTRL_L);
                     end
                     default: sym_held = pressed;
                  endcase
               end else if (pressed) begin
                  if (!have_lead) begin
                     have_lead = 1'b1;
                     lead_tags = {2'b00, entry[TAG_ALT_BIT], entry[TAG_SHIFT_BIT]};
                     if (entry[TAG_SHIFT_BIT] != shift_on) add_usage(U_SHIFT_L);
                     if (entry[TAG_ALT_BIT]) add_usage(U_ALT_L);
                     add_usage(entry[7:0]);
                  end else if (entry[15:12] == lead_tags) begin
                     add_usage(entry[7:0]);
                  end
               end
            end
         end
      end

      for (int c = 0; c < COLUMNS; c++) last_scan[c] = rows_now[c];

      if (menu_on) begin
         report_count = 0;
      end else if (jog_enabled) begin
         if (scan_in.jog_back) begin
            if (!rows_now[1][6] && !rows_now[2][3]) begin
               menu_on = 1'b1;
               report_count = 0;
            end else begin
               add_usage(U_ESC);
               jog_codes++;
            end
         end else if (scan_in.jog_enter) begin
            add_usage(U_TAB);
            jog_codes++;
         end else if (scan_in.jog_up) begin
            add_usage(sym_held ? U_RIGHT : U_UP);
            jog_codes++;
         end else if (scan_in.jog_down) begin
            add_usage(sym_held ? U_LEFT : U_DOWN);
            jog_codes++;
         end
      end

      for (int i = report_count; i < REPORT_SLOTS; i++) report_codes[i] = '0;
      if (report_count == REPORT_SLOTS) full_reports++;
      rep.slot_zero  = report_codes[0];
      rep.slot_one   = report_codes[1];
      rep.slot_two   = report_codes[2];
      rep.slot_three = report_codes[3];
      rep.slot_four  = report_codes[4];
      rep.slot_five  = report_codes[5];
      rep.used_slots = report_count[2:0];
      return rep;
   endfunction

   // sender: bursts of transfers separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = $urandom_range(1, 12);
         gap_left   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            report_queue.push_back(predict_report(req_data));
            scans_sent++;
         end
         if (req_valid && req_stall) begin
            // hold the stalled transfer
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (scan_queue.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= scan_queue.pop_front();
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: check each report, then pick the next stall value
   always @(posedge clock) begin : receive
      rsp_payload_type want;
      logic [7:0]      got_f  [7];
      logic [7:0]      want_f [7];
      logic            bad;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (report_queue.size() == 0) begin
            error_count++;
            if (error_count <= ERR_PRINT_MAX)
               $display("ERROR: report with none expected: %h", rsp_data);
         end else begin
            want   = report_queue.pop_front();
            got_f  = '{rsp_data.slot_zero, rsp_data.slot_one, rsp_data.slot_two,
                       rsp_data.slot_three, rsp_data.slot_four, rsp_data.slot_five,
                       {5'b0, rsp_data.used_slots}};
            want_f = '{want.slot_zero, want.slot_one, want.slot_two,
                       want.slot_three, want.slot_four, want.slot_five,
                       {5'b0, want.used_slots}};
            bad = 1'b0;
            for (int i = 0; i < 7; i++)
               if (got_f[i] !== want_f[i]) bad = 1'b1;
            if (bad) begin
               error_count++;
               if (error_count <= ERR_PRINT_MAX) begin
                  $display("ERROR: report %0d expected %h %h %h %h %h %h used %0d",
                           reports_checked, want_f[0], want_f[1], want_f[2], want_f[3],
                           want_f[4], want_f[5], want_f[6]);
                  $display("       got %h %h %h %h %h %h used %0d",
                           got_f[0], got_f[1], got_f[2], got_f[3], got_f[4], got_f[5],
                           got_f[6]);
               end
            end
            reports_checked++;
         end
      end

      cycle_count++;
      if (cycle_count % 300 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= $urandom_range(0, 1);
         2: rsp_stall <= (cycle_count % 5) < 2;
         default: begin
            if (stall_run == 0) begin
               stall_run   = $urandom_range(1, 50);
               stall_level = !stall_level;
            end else begin
               stall_run--;
            end
            rsp_stall <= stall_level;
         end
      endcase
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ERROR: no transfer for %0d cycles", idle_cycles);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic wait_drained();
      while (scan_queue.size() != 0 || req_valid || report_queue.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_jog(input logic value);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      jog_enabled = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_random(input int count, input bit allow_menu);
      for (int i = 0; i < count; i++) scan_queue.push_back(random_scan(allow_menu));
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = make_scan('0, BTN_NONE);
      rsp_stall   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = 1'b0;
      for (int c = 0; c < COLUMNS; c++) last_scan[c] = '1;
      alt_held = 1'b0;
      sym_held = 1'b0;
      shift_on = 1'b0;
      ctrl_held = 1'b0;
      menu_on = 1'b0;
      jog_enabled = 1'b0;
      error_count = 0;
      scans_sent = 0;
      reports_checked = 0;
      full_reports = 0;
      jog_codes = 0;
      idle_cycles = 0;
      cycle_count = 0;
      stall_mode = 0;
      stall_run = 0;
      stall_level = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // jog dial off: keys, modifiers, layers, tag filtering, full report
      write_jog(1'b0);
      scan_queue.push_back(make_scan('0, BTN_NONE));
      scan_queue.push_back(make_scan('1, BTN_BACK | BTN_ENTER | BTN_UP | BTN_DOWN));
      scan_queue.push_back(make_scan(key_at(0, 0), BTN_NONE));
      scan_queue.push_back(make_scan(K_SHIFT | key_at(0, 0), BTN_NONE));
      scan_queue.push_back(make_scan(K_SHIFT | key_at(4, 4) | key_at(0, 1), BTN_NONE));
      scan_queue.push_back(make_scan('0, BTN_NONE));
      scan_queue.push_back(make_scan(K_CTRL | key_at(3, 3), BTN_NONE));
      scan_queue.push_back(make_scan(K_ALT, BTN_NONE));
      scan_queue.push_back(make_scan(K_ALT | key_at(1, 0) | key_at(0, 5), BTN_NONE));
      scan_queue.push_back(make_scan(K_ALT | K_SYM, BTN_NONE));
      scan_queue.push_back(make_scan(K_ALT | K_SYM | key_at(0, 6) | key_at(3, 3), BTN_NONE));
      scan_queue.push_back(make_scan(K_SYM | key_at(0, 0) | key_at(0, 1), BTN_NONE));
      scan_queue.push_back(make_scan(key_at(0, 0) | key_at(0, 1) | key_at(1, 0) | key_at(1, 1)
                                     | key_at(2, 0) | key_at(2, 1) | key_at(3, 0)
                                     | key_at(4, 0), BTN_NONE));
      // menu combination is inert while the jog dial is off
      scan_queue.push_back(make_scan(K_SHIFT | K_CTRL, BTN_BACK));
      queue_random(400, 1'b0);

      // jog dial on: button priority, sym arrows, jog code dropped when full
      write_jog(1'b1);
      scan_queue.push_back(make_scan('0, BTN_BACK));
      scan_queue.push_back(make_scan('0, BTN_ENTER | BTN_UP | BTN_DOWN));
      scan_queue.push_back(make_scan('0, BTN_UP));
      scan_queue.push_back(make_scan('0, BTN_DOWN));
      scan_queue.push_back(make_scan(K_SYM, BTN_UP));
      scan_queue.push_back(make_scan(K_SYM, BTN_DOWN));
      scan_queue.push_back(make_scan('0, BTN_UP));
      scan_queue.push_back(make_scan('1, BTN_ENTER));
      scan_queue.push_back(make_scan(K_CTRL | key_at(0, 0) | key_at(0, 1) | key_at(1, 0),
                                     BTN_BACK));
      queue_random(550, 1'b0);

      write_jog(1'b0);
      queue_random(300, 1'b0);

      // last phase ends in menu mode, which only a reset clears
      write_jog(1'b1);
      queue_random(400, 1'b0);
      scan_queue.push_back(make_scan(K_SHIFT | K_CTRL, BTN_BACK));
      queue_random(25, 1'b1);

      wait_drained();
      repeat (100) @(posedge clock);
      if (report_queue.size() != 0) begin
         $display("ERROR: %0d reports never arrived", report_queue.size());
         error_count += report_queue.size();
      end
      $display("Checked %0d reports from %0d scans over four jog-dial settings",
               reports_checked, scans_sent);
      $display("%0d reports full, %0d jog codes predicted, menu mode reached: %0d",
               full_reports, jog_codes, menu_on);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> filelist.f
sv/lkm_pkg.sv
sv/lkm_front.sv
sv/lkm_back.sv
sv/layered_key_matrix_to_hid_report_core.sv
sv/lkm_checker.sv
tb/sv/tb_layered_key_matrix_to_hid_report_core.sv
